### src/hfn_pkg.sv
// Shared constants, register codes and unit interface types for the height field normal stream.
// Used by hfn_norm_unit and height_field_normal_stream_core; depends on nothing else.
package hfn_pkg;

    localparam int HEIGHT_BITS  = 16;
    localparam int MAX_COLUMNS  = 256;
    localparam int COL_BITS     = 8;
    localparam int ADDR_BITS    = $clog2(MAX_COLUMNS);
    localparam int ROW_BITS     = 12;
    localparam int CFG_BITS     = 12;
    localparam int DIFF_BITS    = HEIGHT_BITS + 1;
    localparam int MAG_BITS     = DIFF_BITS + 3;
    localparam int COMP_BITS    = 17;
    localparam int SHIFT_BITS   = 5;
    localparam int SQ_BITS      = 2 * COMP_BITS;
    localparam int SUM_BITS     = SQ_BITS + 2;
    localparam int REM_BITS     = SUM_BITS + 1;
    localparam int FRAC_STEPS   = 28;
    localparam int Q_BITS       = FRAC_STEPS + 1;
    localparam int QS_BITS      = Q_BITS + 1;
    localparam int ROOT_BITS    = QS_BITS / 2;
    localparam int RT_REM_BITS  = ROOT_BITS + 2;
    localparam int CNT_BITS     = 5;
    localparam int NORM_BITS    = 16;
    localparam int UNIT_Q12     = 4096;

    localparam logic [COL_BITS-1:0] LAST_COLUMN_RESET = 8'd128;
    localparam logic [ROW_BITS-1:0] LAST_ROW_RESET    = 12'd128;

    typedef enum logic {
        REG_LAST_COLUMN = 1'b0,
        REG_LAST_ROW    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DIFF_BITS-1:0] dx;
        logic signed [DIFF_BITS-1:0] dz;
    } norm_req_t;

    typedef struct packed {
        logic [ROOT_BITS-1:0] mag_x;
        logic [ROOT_BITS-1:0] mag_y;
        logic [ROOT_BITS-1:0] mag_z;
        logic                 neg_x;
        logic                 neg_z;
    } norm_rsp_t;

endpackage

### src/height_field_normal_stream_core.sv
// Top level of the height field normal stream: line buffers, raster counters and result output.
// Depends on hfn_pkg and instantiates hfn_norm_unit.
//
// Each height item passes through the line buffer states (reads of the neighbors and one write),
// then zero to three normals. Each normal runs through the bit-serial normalizer: one setup
// state, three squarings, one sum and, for each of the three components, 29 division steps
// and 15 square root steps. Row zero items yield no normals, and only last row items can yield
// more than one. The next item is taken once every result of the current one has been accepted.
module height_field_normal_stream_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hfn_pkg::HEIGHT_BITS-1:0] s_height,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [hfn_pkg::NORM_BITS-1:0] m_normal_x,
    output logic [hfn_pkg::ROOT_BITS-1:0]        m_normal_y,
    output logic signed [hfn_pkg::NORM_BITS-1:0] m_normal_z,
    output logic [hfn_pkg::COL_BITS-1:0]         m_point_column,
    output logic [hfn_pkg::ROW_BITS-1:0]         m_point_row,
    output logic                                 m_last_in_run,
    input  logic                                 cfg_wr_en,
    input  logic [0:0]                           cfg_index,
    input  logic [hfn_pkg::CFG_BITS-1:0]         cfg_wdata
);

    typedef enum logic [7:0] {
        T_IDLE = 8'b00000001,
        T_RD0  = 8'b00000010,
        T_RD1  = 8'b00000100,
        T_RD2  = 8'b00001000,
        T_RD3  = 8'b00010000,
        T_SEL  = 8'b00100000,
        T_CALC = 8'b01000000,
        T_OUT  = 8'b10000000
    } tstate_t;

    tstate_t state_reg;
    logic [hfn_pkg::COL_BITS-1:0] last_column_reg;
    logic [hfn_pkg::ROW_BITS-1:0] last_row_reg;
    logic [hfn_pkg::COL_BITS-1:0] column_count_reg;
    logic [hfn_pkg::ROW_BITS-1:0] row_count_reg;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] prev_sample_reg;

    logic [hfn_pkg::HEIGHT_BITS-1:0] mem_a [hfn_pkg::MAX_COLUMNS];
    logic [hfn_pkg::HEIGHT_BITS-1:0] mem_b [hfn_pkg::MAX_COLUMNS];
    logic [hfn_pkg::HEIGHT_BITS-1:0] rd_a_reg;
    logic [hfn_pkg::HEIGHT_BITS-1:0] rd_b_reg;
    logic [hfn_pkg::ADDR_BITS-1:0]   addr_a;
    logic [hfn_pkg::ADDR_BITS-1:0]   addr_b;

    logic signed [hfn_pkg::HEIGHT_BITS-1:0] h_reg;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] prev_reg;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] a_c_reg;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] a_c1_reg;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] a_cm2_reg;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] b_c_reg;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] b_cm1_reg;
    logic [hfn_pkg::COL_BITS-1:0] c_reg;
    logic [hfn_pkg::ROW_BITS-1:0] r_reg;
    logic [2:0]                   pend_reg;

    logic [hfn_pkg::COL_BITS-1:0] c_sat;
    logic [hfn_pkg::ROW_BITS-1:0] r_sat;
    logic                         final_row;
    logic                         final_col;
    logic                         first_row;
    logic                         accept;

    logic [2:0]                   pend_next;
    logic                         sel_first;
    logic                         sel_second;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] e_left;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] e_right;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] e_up;
    logic signed [hfn_pkg::HEIGHT_BITS-1:0] e_down;
    logic [hfn_pkg::COL_BITS-1:0] e_col;
    logic [hfn_pkg::ROW_BITS-1:0] e_row;

    hfn_pkg::norm_req_t req;
    hfn_pkg::norm_rsp_t rsp;
    logic               unit_start;
    logic               unit_done;

    logic signed [hfn_pkg::NORM_BITS-1:0] nx_reg;
    logic [hfn_pkg::ROOT_BITS-1:0]        ny_reg;
    logic signed [hfn_pkg::NORM_BITS-1:0] nz_reg;
    logic [hfn_pkg::COL_BITS-1:0]         out_col_reg;
    logic [hfn_pkg::ROW_BITS-1:0]         out_row_reg;
    logic                                 out_last_reg;

    function automatic logic signed [hfn_pkg::DIFF_BITS-1:0] diff_of(
        input logic signed [hfn_pkg::HEIGHT_BITS-1:0] p,
        input logic signed [hfn_pkg::HEIGHT_BITS-1:0] q
    );
        return {p[hfn_pkg::HEIGHT_BITS-1], p} - {q[hfn_pkg::HEIGHT_BITS-1], q};
    endfunction

    always_comb begin
        c_sat     = (column_count_reg > last_column_reg) ? last_column_reg : column_count_reg;
        r_sat     = (row_count_reg > last_row_reg) ? last_row_reg : row_count_reg;
        final_row = (r_sat == last_row_reg);
        final_col = (c_sat == last_column_reg);
        first_row = (r_sat == '0);
        accept    = s_valid && s_ready;
    end

    always_comb begin
        addr_a = c_reg;
        addr_b = c_reg;
        unique case (state_reg)
            T_RD1: begin
                addr_a = c_reg + 1'b1;
                addr_b = c_reg - 1'b1;
            end
            T_RD2: begin
                addr_a = c_reg - 2'd2;
            end
            default: begin
                addr_a = c_reg;
                addr_b = c_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
        if (state_reg == T_RD3) begin
            mem_a[c_reg] <= h_reg;
            mem_b[c_reg] <= a_c_reg;
        end
    end

    always_comb begin
        sel_first  = pend_reg[0];
        sel_second = !pend_reg[0] && pend_reg[1];
        pend_next  = pend_reg;
        if (sel_first) begin
            pend_next[0] = 1'b0;
            e_left  = (c_reg != '0) ? b_cm1_reg : a_c_reg;
            e_right = (c_reg != last_column_reg) ? a_c1_reg : a_c_reg;
            e_up    = h_reg;
            e_down  = (r_reg > hfn_pkg::ROW_BITS'(1)) ? b_c_reg : a_c_reg;
            e_col   = c_reg;
            e_row   = r_reg - 1'b1;
        end else if (sel_second) begin
            pend_next[1] = 1'b0;
            e_left  = (c_reg > hfn_pkg::COL_BITS'(1)) ? a_cm2_reg : prev_reg;
            e_right = h_reg;
            e_up    = prev_reg;
            e_down  = b_cm1_reg;
            e_col   = c_reg - 1'b1;
            e_row   = r_reg;
        end else begin
            pend_next[2] = 1'b0;
            e_left  = (c_reg != '0) ? prev_reg : h_reg;
            e_right = h_reg;
            e_up    = h_reg;
            e_down  = a_c_reg;
            e_col   = c_reg;
            e_row   = r_reg;
        end
        req.dx     = diff_of(e_right, e_left);
        req.dz     = diff_of(e_up, e_down);
        unit_start = (state_reg == T_SEL) && (pend_reg != '0);
    end

    hfn_norm_unit u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (unit_start),
        .req     (req),
        .done    (unit_done),
        .rsp     (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= T_IDLE;
            last_column_reg  <= hfn_pkg::LAST_COLUMN_RESET;
            last_row_reg     <= hfn_pkg::LAST_ROW_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            prev_sample_reg  <= '0;
            pend_reg         <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    hfn_pkg::REG_LAST_COLUMN:
                        last_column_reg <= cfg_wdata[hfn_pkg::COL_BITS-1:0];
                    hfn_pkg::REG_LAST_ROW:
                        last_row_reg <= cfg_wdata[hfn_pkg::ROW_BITS-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        h_reg    <= s_height;
                        prev_reg <= prev_sample_reg;
                        c_reg    <= c_sat;
                        r_reg    <= r_sat;
                        pend_reg <= {!first_row && final_row && final_col,
                                     !first_row && final_row && (c_sat != '0),
                                     !first_row};
                        prev_sample_reg <= s_height;
                        if (final_col) begin
                            column_count_reg <= '0;
                            row_count_reg    <= final_row ? '0 : r_sat + 1'b1;
                        end else begin
                            column_count_reg <= c_sat + 1'b1;
                        end
                        state_reg <= T_RD0;
                    end
                end
                T_RD0: state_reg <= T_RD1;
                T_RD1: begin
                    a_c_reg   <= rd_a_reg;
                    b_c_reg   <= rd_b_reg;
                    state_reg <= T_RD2;
                end
                T_RD2: begin
                    a_c1_reg  <= rd_a_reg;
                    b_cm1_reg <= rd_b_reg;
                    state_reg <= T_RD3;
                end
                T_RD3: begin
                    a_cm2_reg <= rd_a_reg;
                    state_reg <= T_SEL;
                end
                T_SEL: begin
                    if (pend_reg == '0) begin
                        state_reg <= T_IDLE;
                    end else begin
                        out_col_reg  <= e_col;
                        out_row_reg  <= e_row;
                        out_last_reg <= (pend_next == '0);
                        pend_reg     <= pend_next;
                        state_reg    <= T_CALC;
                    end
                end
                T_CALC: begin
                    if (unit_done) begin
                        nx_reg <= rsp.neg_x ? -hfn_pkg::NORM_BITS'(rsp.mag_x)
                                            : hfn_pkg::NORM_BITS'(rsp.mag_x);
                        ny_reg <= rsp.mag_y;
                        nz_reg <= rsp.neg_z ? -hfn_pkg::NORM_BITS'(rsp.mag_z)
                                            : hfn_pkg::NORM_BITS'(rsp.mag_z);
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (m_ready) begin
                        state_reg <= T_SEL;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == T_IDLE);
    assign m_valid        = (state_reg == T_OUT);
    assign m_normal_x     = nx_reg;
    assign m_normal_y     = ny_reg;
    assign m_normal_z     = nz_reg;
    assign m_point_column = out_col_reg;
    assign m_point_row    = out_row_reg;
    assign m_last_in_run  = out_last_reg;

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        unit_done |-> state_reg == T_CALC)
        else $error("Normalizer finished outside the calculation state.");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Input taken while a result is pending.");

    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_in_run) |-> pend_reg == '0)
        else $error("Final result shown while normals remain pending.");

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == T_RD0)
        else $error("Accepted item did not start the line buffer reads.");

endmodule

### src/hfn_norm_unit.sv
// Bit-serial unit normal of (-10dx, 1, -10dz): squares, restoring division and digit square root.
// Depends on hfn_pkg for widths and the request and response types.
module hfn_norm_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  hfn_pkg::norm_req_t req,
    output logic              done,
    output hfn_pkg::norm_rsp_t rsp
);

    localparam int RT_REM_BITS_W = hfn_pkg::RT_REM_BITS + 2;

    typedef enum logic [5:0] {
        N_IDLE = 6'b000001,
        N_PREP = 6'b000010,
        N_SQ   = 6'b000100,
        N_SUM  = 6'b001000,
        N_DIV  = 6'b010000,
        N_SQRT = 6'b100000
    } nstate_t;

    nstate_t state_reg;
    logic signed [hfn_pkg::DIFF_BITS-1:0] dx_reg;
    logic signed [hfn_pkg::DIFF_BITS-1:0] dz_reg;
    logic [hfn_pkg::COMP_BITS-1:0]   m_reg [3];
    logic [hfn_pkg::SQ_BITS-1:0]     sq_reg [3];
    logic [hfn_pkg::ROOT_BITS-1:0]   res_reg [3];
    logic [hfn_pkg::SUM_BITS-1:0]    sum_reg;
    logic [hfn_pkg::REM_BITS-1:0]    rem_reg;
    logic [hfn_pkg::FRAC_STEPS-1:0]  quo_reg;
    logic [hfn_pkg::QS_BITS-1:0]     qs_reg;
    logic [hfn_pkg::RT_REM_BITS-1:0] rt_rem_reg;
    logic [hfn_pkg::ROOT_BITS-1:0]   root_reg;
    logic [hfn_pkg::CNT_BITS-1:0]    cnt_reg;
    logic [1:0]                      comp_reg;
    logic                            neg_x_reg;
    logic                            neg_z_reg;
    logic                            done_reg;

    logic [hfn_pkg::DIFF_BITS-1:0]   abs_x;
    logic [hfn_pkg::DIFF_BITS-1:0]   abs_z;
    logic [hfn_pkg::MAG_BITS-1:0]    mag_x;
    logic [hfn_pkg::MAG_BITS-1:0]    mag_z;
    logic [hfn_pkg::MAG_BITS-1:0]    mag_hi;
    logic [hfn_pkg::SHIFT_BITS-1:0]  shift;
    logic [hfn_pkg::REM_BITS-1:0]    div_t;
    logic [hfn_pkg::REM_BITS-1:0]    div_s;
    logic                            div_ge;
    logic [RT_REM_BITS_W-1:0]        rt_next;
    logic [RT_REM_BITS_W-1:0]        rt_trial;
    logic                            rt_ge;

    always_comb begin
        abs_x = dx_reg[hfn_pkg::DIFF_BITS-1] ? hfn_pkg::DIFF_BITS'(-dx_reg) : dx_reg;
        abs_z = dz_reg[hfn_pkg::DIFF_BITS-1] ? hfn_pkg::DIFF_BITS'(-dz_reg) : dz_reg;
        mag_x = (hfn_pkg::MAG_BITS'(abs_x) << 3) + (hfn_pkg::MAG_BITS'(abs_x) << 1);
        mag_z = (hfn_pkg::MAG_BITS'(abs_z) << 3) + (hfn_pkg::MAG_BITS'(abs_z) << 1);
        mag_hi = mag_x | mag_z;
        shift = '0;
        for (int i = 0; i < hfn_pkg::MAG_BITS - hfn_pkg::COMP_BITS; i++) begin
            if (mag_hi[hfn_pkg::COMP_BITS + i]) begin
                shift = hfn_pkg::SHIFT_BITS'(i + 1);
            end
        end
    end

    always_comb begin
        div_s = hfn_pkg::REM_BITS'(sum_reg);
        if (cnt_reg == '0) begin
            div_t = hfn_pkg::REM_BITS'(sq_reg[comp_reg]);
        end else begin
            div_t = rem_reg << 1;
        end
        div_ge = (div_t >= div_s);
        rt_next  = {rt_rem_reg, qs_reg[hfn_pkg::QS_BITS-1 -: 2]};
        rt_trial = {2'b00, root_reg, 2'b01};
        rt_ge    = (rt_next >= rt_trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE: begin
                    if (start) begin
                        dx_reg    <= req.dx;
                        dz_reg    <= req.dz;
                        state_reg <= N_PREP;
                    end
                end
                N_PREP: begin
                    m_reg[0]  <= hfn_pkg::COMP_BITS'(mag_x >> shift);
                    m_reg[1]  <= hfn_pkg::COMP_BITS'(hfn_pkg::UNIT_Q12 >> shift);
                    m_reg[2]  <= hfn_pkg::COMP_BITS'(mag_z >> shift);
                    neg_x_reg <= ~dx_reg[hfn_pkg::DIFF_BITS-1] & (|dx_reg);
                    neg_z_reg <= ~dz_reg[hfn_pkg::DIFF_BITS-1] & (|dz_reg);
                    cnt_reg   <= '0;
                    state_reg <= N_SQ;
                end
                N_SQ: begin
                    sq_reg[cnt_reg[1:0]] <= m_reg[cnt_reg[1:0]] * m_reg[cnt_reg[1:0]];
                    if (cnt_reg == hfn_pkg::CNT_BITS'(2)) begin
                        cnt_reg   <= '0;
                        state_reg <= N_SUM;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                N_SUM: begin
                    sum_reg <= hfn_pkg::SUM_BITS'(sq_reg[0]) + hfn_pkg::SUM_BITS'(sq_reg[1])
                             + hfn_pkg::SUM_BITS'(sq_reg[2]);
                    comp_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= N_DIV;
                end
                N_DIV: begin
                    rem_reg <= div_ge ? div_t - div_s : div_t;
                    quo_reg <= {quo_reg[hfn_pkg::FRAC_STEPS-2:0], div_ge};
                    if (cnt_reg == hfn_pkg::CNT_BITS'(hfn_pkg::FRAC_STEPS)) begin
                        qs_reg     <= {1'b0, quo_reg, div_ge};
                        root_reg   <= '0;
                        rt_rem_reg <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= N_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                N_SQRT: begin
                    rt_rem_reg <= rt_ge ? hfn_pkg::RT_REM_BITS'(rt_next - rt_trial)
                                        : hfn_pkg::RT_REM_BITS'(rt_next);
                    root_reg   <= {root_reg[hfn_pkg::ROOT_BITS-2:0], rt_ge};
                    qs_reg     <= qs_reg << 2;
                    if (cnt_reg == hfn_pkg::CNT_BITS'(hfn_pkg::ROOT_BITS - 1)) begin
                        res_reg[comp_reg] <= {root_reg[hfn_pkg::ROOT_BITS-2:0], rt_ge};
                        cnt_reg <= '0;
                        if (comp_reg == 2'd2) begin
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end else begin
                            comp_reg  <= comp_reg + 1'b1;
                            state_reg <= N_DIV;
                        end
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    assign done      = done_reg;
    assign rsp.mag_x = res_reg[0];
    assign rsp.mag_y = res_reg[1];
    assign rsp.mag_z = res_reg[2];
    assign rsp.neg_x = neg_x_reg;
    assign rsp.neg_z = neg_z_reg;

endmodule
